// ===== sv/salc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types and constants of the set-associative LRU cache model.
// ----------------------------------------------------------------------------
package salc_pkg;

    localparam int MAX_SET_BITS = 6;
    localparam int MAX_WAYS     = 8;

    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int NW_W     = $clog2(MAX_WAYS + 1);
    localparam int SB_W     = $clog2(MAX_SET_BITS + 1) > 3 ? $clog2(MAX_SET_BITS + 1) : 3;

    // Access kinds carried in the input tuser.
    localparam logic [1:0] OP_IFETCH = 2'd0;
    localparam logic [1:0] OP_LOAD   = 2'd1;
    localparam logic [1:0] OP_STORE  = 2'd2;
    localparam logic [1:0] OP_MODIFY = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [1:0] CFG_WAYS       = 2'd1;
    localparam logic [1:0] CFG_BLOCK_BITS = 2'd2;

    typedef struct packed {
        logic        valid;
        logic [31:0] tag;
        logic [31:0] stamp;
    } t_way;

    typedef t_way [MAX_WAYS-1:0] t_row;

    typedef struct packed {
        logic             en;
        logic [SET_W-1:0] addr;
        t_row             data;
    } t_ram_wr;

endpackage

// ===== sv/salc_row_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_row_ram
// One row per set holding tag and stamp of every way; one write port and one
// read port with registered read data.
// ----------------------------------------------------------------------------
module salc_row_ram
    import salc_pkg::*;
(
    input  logic             i_clk,
    input  t_ram_wr          i_wr,
    input  logic             i_rd_en,
    input  logic [SET_W-1:0] i_rd_addr,
    output t_row             o_rd_row
);

    t_row mem [NUM_SETS];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            o_rd_row <= mem[i_rd_addr];
        end
    end

endmodule

// ===== sv/set_assoc_lru_cache_model_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model_top
// Set-associative cache model with LRU replacement and outcome counters.
// ----------------------------------------------------------------------------
// Usage:
// An access enters on the s_axis channel: the access kind in tuser and the
// byte address in tdata. One result per access leaves on the m_axis channel
// with the hit, miss, eviction and second-hit flags and the running totals.
// The config channel writes set_bits, ways and block_bits; it is always
// ready and should only be used while no access is in progress.
// The block takes no new access until the result of the last one is in the
// output register: the set row is read from the row memory, S_LOOK
// compares tags and does the first stage of the oldest-stamp search, and
// S_WRITE finishes the search and writes the row back for data accesses.
// Results sit in an output register; while a result waits for the receiver,
// no further access is taken.
// After reset a clearing pass writes all 64 set rows empty, one per cycle, and
// the input is held off until it ends; the counters reset to zero.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_model_top
    import salc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // [31:0] address
    input  logic [1:0]   s_axis_tuser,   // [1:0] operation
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [0] hit, [1] miss, [2] eviction, [3] second_hit, [35:4] hit_total,
    // [67:36] miss_total, [99:68] eviction_total, [103:100] zero
    output logic [103:0] m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [4:0]   i_cfg_data
);

    localparam int PAIRS = (MAX_WAYS + 1) / 2;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_LOOK  = 4'b0010,
        S_WRITE = 4'b0100,
        S_CLEAR = 4'b1000
    } t_state;

    typedef struct packed {
        logic             ok;
        logic [31:0]      stamp;
        logic [WAY_W-1:0] way;
    } t_cand;

    // Keeps a unless b is a candidate and a is not, or b has a strictly smaller stamp.
    function automatic t_cand pick_older(t_cand a, t_cand b);
        t_cand res;
        res = a;
        if (b.ok && (!a.ok || (b.stamp < a.stamp))) begin
            res = b;
        end
        return res;
    endfunction

    t_state r_state;
    logic [SET_W-1:0] r_clr_addr;

    logic [2:0]  r_set_bits;
    logic [3:0]  r_ways;
    logic [4:0]  r_block_bits;

    logic [31:0] r_counter;
    logic [31:0] r_hits;
    logic [31:0] r_misses;
    logic [31:0] r_evicts;

    logic [1:0]       r_op;
    logic [SET_W-1:0] r_set;
    logic [31:0]      r_tag;
    logic [NW_W-1:0]  r_nw;

    logic             r_hit_f;
    logic [WAY_W-1:0] r_hit_way;
    logic             r_inv_f;
    logic [WAY_W-1:0] r_inv_way;
    t_cand            r_l1 [PAIRS];

    logic         r_out_valid;
    logic [103:0] r_out_data;

    logic             s_acc;
    logic [SB_W-1:0]  sb;
    logic [NW_W-1:0]  nw;
    logic [31:0]      above;
    logic [SET_W-1:0] acc_set;
    logic [31:0]      acc_tag;

    t_row                rd_row;
    t_ram_wr             ram_wr;
    logic [MAX_WAYS-1:0] in_use;
    logic                n_hit_f;
    logic [WAY_W-1:0]    n_hit_way;
    logic                n_inv_f;
    logic [WAY_W-1:0]    n_inv_way;
    t_cand               n_l1 [PAIRS];

    t_cand            oldest;
    logic             is_data;
    logic             evict_f;
    logic [WAY_W-1:0] sel_way;
    logic [31:0]      n_hits;
    logic [31:0]      n_misses;
    logic [31:0]      n_evicts;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || m_axis_tready);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Address split for the incoming access.
    always_comb begin
        if (32'(r_set_bits) > MAX_SET_BITS) begin
            sb = SB_W'(MAX_SET_BITS);
        end else begin
            sb = SB_W'(r_set_bits);
        end
        if (r_ways == 4'd0) begin
            nw = NW_W'(1);
        end else if (32'(r_ways) > MAX_WAYS) begin
            nw = NW_W'(MAX_WAYS);
        end else begin
            nw = NW_W'(r_ways);
        end
        above   = s_axis_tdata >> r_block_bits;
        acc_set = SET_W'(above & ((32'd1 << sb) - 32'd1));
        acc_tag = above >> sb;
    end

    salc_row_ram u_row_ram (
        .i_clk     (i_clk),
        .i_wr      (ram_wr),
        .i_rd_en   (s_acc),
        .i_rd_addr (acc_set),
        .o_rd_row  (rd_row)
    );

    // Tag compare, first free way and first level of the oldest-stamp search.
    always_comb begin
        t_cand a;
        t_cand b;
        n_hit_f   = 1'b0;
        n_hit_way = '0;
        n_inv_f   = 1'b0;
        n_inv_way = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            in_use[w] = NW_W'(w) < r_nw;
        end
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (in_use[w] && rd_row[w].valid && (rd_row[w].tag == r_tag)) begin
                n_hit_f   = 1'b1;
                n_hit_way = WAY_W'(w);
            end
            if (in_use[w] && !rd_row[w].valid) begin
                n_inv_f   = 1'b1;
                n_inv_way = WAY_W'(w);
            end
        end
        for (int p = 0; p < PAIRS; p++) begin
            a = '{ok: in_use[2*p], stamp: rd_row[2*p].stamp, way: WAY_W'(2*p)};
            b = '{ok: 1'b0, stamp: '0, way: '0};
            if (2*p + 1 < MAX_WAYS) begin
                b = '{ok: in_use[2*p+1], stamp: rd_row[2*p+1].stamp, way: WAY_W'(2*p+1)};
            end
            n_l1[p] = pick_older(a, b);
        end
    end

    // Finish the search, choose the way, build the row write (or the clearing write) and the new totals.
    always_comb begin
        oldest = r_l1[0];
        for (int p = 1; p < PAIRS; p++) begin
            oldest = pick_older(oldest, r_l1[p]);
        end
        is_data = (r_op != OP_IFETCH);
        evict_f = is_data && !r_hit_f && !r_inv_f;
        if (r_hit_f) begin
            sel_way = r_hit_way;
        end else if (r_inv_f) begin
            sel_way = r_inv_way;
        end else begin
            sel_way = oldest.way;
        end
        ram_wr.en   = ((r_state == S_WRITE) && is_data) || (r_state == S_CLEAR);
        ram_wr.addr = r_set;
        ram_wr.data = rd_row;
        ram_wr.data[sel_way] = '{valid: 1'b1, tag: r_tag, stamp: r_counter};
        if (r_state == S_CLEAR) begin
            ram_wr.addr = r_clr_addr;
            ram_wr.data = '0;
        end

        n_hits   = r_hits + 32'(is_data && r_hit_f) + 32'(r_op == OP_MODIFY);
        n_misses = r_misses + 32'(is_data && !r_hit_f);
        n_evicts = r_evicts + 32'(evict_f);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_set_bits   <= 3'd4;
            r_ways       <= 4'd1;
            r_block_bits <= 5'd4;
            r_counter    <= '0;
            r_hits       <= '0;
            r_misses     <= '0;
            r_evicts     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SET_BITS:   r_set_bits   <= i_cfg_data[2:0];
                    CFG_WAYS:       r_ways       <= i_cfg_data[3:0];
                    CFG_BLOCK_BITS: r_block_bits <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + SET_W'(1);
                    if (r_clr_addr == SET_W'(NUM_SETS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_acc) begin
                        r_counter <= r_counter + 32'd1;
                        r_state   <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    r_hits      <= n_hits;
                    r_misses    <= n_misses;
                    r_evicts    <= n_evicts;
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Payload registers of the access in flight.
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_op  <= s_axis_tuser;
            r_set <= acc_set;
            r_tag <= acc_tag;
            r_nw  <= nw;
        end
        if (r_state == S_LOOK) begin
            r_hit_f   <= n_hit_f;
            r_hit_way <= n_hit_way;
            r_inv_f   <= n_inv_f;
            r_inv_way <= n_inv_way;
            for (int p = 0; p < PAIRS; p++) begin
                r_l1[p] <= n_l1[p];
            end
        end
        if (r_state == S_WRITE) begin
            r_out_data <= {4'd0, n_evicts, n_misses, n_hits,
                           (r_op == OP_MODIFY), evict_f,
                           (is_data && !r_hit_f), (is_data && r_hit_f)};
        end
    end

    // Every accepted access shows its result once S_LOOK and S_WRITE have passed.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |-> ##3 m_axis_tvalid)
        else $error("result did not appear three cycles after the input transfer");

    // An eviction is always also a miss.
    a_evict_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[2]) |-> m_axis_tdata[1])
        else $error("eviction reported without a miss");

    // The way written back lies within the ways in use.
    a_way_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WRITE) && is_data) |-> (NW_W'(sel_way) < r_nw))
        else $error("write-back way beyond the configured ways");

    // The miss total moves only with a reported miss.
    a_miss_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |=> (r_misses == $past(r_misses) + 32'(m_axis_tdata[1])))
        else $error("miss total out of step with the miss flag");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the set-associative LRU cache model.
// Accesses and register writes are fed from one request queue. A behavioral
// cache model predicts the flags and running totals of every accepted access,
// and each result on m_axis is compared against the oldest prediction. A short
// directed run is followed by random traffic under several geometries. The
// traffic is aimed at a few sets and tags so that hits and evictions are
// frequent. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb;
    import salc_pkg::*;

    localparam int NUM_LINES = NUM_SETS * MAX_WAYS;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  cfg_index;
        logic [4:0]  cfg_value;
        logic [1:0]  op;
        logic [31:0] addr;
    } req_t;

    // Same bit order as m_axis_tdata, hit in bit 0.
    typedef struct packed {
        logic [31:0] eviction_total;
        logic [31:0] miss_total;
        logic [31:0] hit_total;
        logic        second_hit;
        logic        eviction;
        logic        miss;
        logic        hit;
    } outcome_t;

    logic         i_clk;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata  = '0;
    logic [1:0]   s_axis_tuser  = OP_IFETCH;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;
    logic         i_cfg_valid   = 1'b0;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index   = CFG_SET_BITS;
    logic [4:0]   i_cfg_data    = '0;

    set_assoc_lru_cache_model_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Cache model state.
    bit          valid_mem [NUM_LINES];
    logic [31:0] tag_mem   [NUM_LINES];
    logic [31:0] stamp_mem [NUM_LINES];
    logic [31:0] tick;
    logic [31:0] hit_cnt, miss_cnt, evict_cnt;
    logic [2:0]  cur_set_bits;
    logic [3:0]  cur_ways;
    logic [4:0]  cur_block_bits;

    req_t        request_q [$];
    outcome_t    outcome_q [$];
    int unsigned accesses_sent = 0;
    int unsigned outcomes_seen = 0;
    int unsigned fail_cnt      = 0;
    int unsigned cyc           = 0;

    // Geometry as seen by the stimulus generator, ahead of the model.
    int unsigned gen_sb, gen_ways, gen_bb;

    wire calm = (cyc >= 2500) && (cyc < 4000);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic outcome_t cache_lookup(input logic [1:0] op,
                                              input logic [31:0] addr);
        outcome_t    r;
        int unsigned esb, nw, base, w, slot;
        logic [31:0] above, set_idx, tag;
        bit          found;
        r     = '0;
        found = 1'b0;
        slot  = 0;
        tick  = tick + 1;
        if (op != OP_IFETCH) begin
            esb     = (cur_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : cur_set_bits;
            nw      = (cur_ways == 0) ? 1 : ((cur_ways > MAX_WAYS) ? MAX_WAYS : cur_ways);
            above   = addr >> cur_block_bits;
            set_idx = above & ((32'd1 << esb) - 32'd1);
            tag     = above >> esb;
            base    = set_idx * MAX_WAYS;
            for (w = 0; w < nw; w++) begin
                if (!found && valid_mem[base + w] && tag_mem[base + w] == tag) begin
                    found = 1'b1;
                    slot  = w;
                end
            end
            if (found) begin
                r.hit   = 1'b1;
                hit_cnt = hit_cnt + 1;
            end else begin
                r.miss   = 1'b1;
                miss_cnt = miss_cnt + 1;
                for (w = 0; w < nw; w++) begin
                    if (!found && !valid_mem[base + w]) begin
                        found = 1'b1;
                        slot  = w;
                    end
                end
                // Full set: the oldest stamp goes, the lowest way on a tie.
                if (!found) begin
                    slot = 0;
                    for (w = 1; w < nw; w++) begin
                        if (stamp_mem[base + w] < stamp_mem[base + slot])
                            slot = w;
                    end
                    r.eviction = 1'b1;
                    evict_cnt  = evict_cnt + 1;
                end
                tag_mem[base + slot]   = tag;
                valid_mem[base + slot] = 1'b1;
            end
            stamp_mem[base + slot] = tick;
            if (op == OP_MODIFY) begin
                r.second_hit = 1'b1;
                hit_cnt      = hit_cnt + 1;
            end
        end
        r.hit_total      = hit_cnt;
        r.miss_total     = miss_cnt;
        r.eviction_total = evict_cnt;
        return r;
    endfunction

    task automatic queue_access(input logic [1:0] op, input logic [31:0] addr);
        req_t q;
        q           = '{default: '0};
        q.op        = op;
        q.addr      = addr;
        request_q.push_back(q);
    endtask

    task automatic queue_config(input logic [1:0] index, input int unsigned value);
        req_t q;
        q           = '{default: '0};
        q.is_cfg    = 1'b1;
        q.cfg_index = index;
        q.cfg_value = value[4:0];
        request_q.push_back(q);
        case (index)
            CFG_SET_BITS:   gen_sb   = value;
            CFG_WAYS:       gen_ways = value;
            CFG_BLOCK_BITS: gen_bb   = value;
            default: ;
        endcase
    endtask

    task automatic note_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, field, want, got);
    endtask

    // Driver: also feeds the model at each accepted transfer.
    always @(posedge i_clk) begin
        req_t nxt;
        bit   in_busy, cfg_busy;
        cyc <= cyc + 1;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            i_cfg_valid   <= 1'b0;
            cur_set_bits   = 3'd4;
            cur_ways       = 4'd1;
            cur_block_bits = 5'd4;
            for (int k = 0; k < NUM_LINES; k++)
                valid_mem[k] = 1'b0;
            tick      = '0;
            hit_cnt   = '0;
            miss_cnt  = '0;
            evict_cnt = '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                outcome_q.push_back(cache_lookup(s_axis_tuser, s_axis_tdata));
                accesses_sent++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SET_BITS:   cur_set_bits   = i_cfg_data[2:0];
                    CFG_WAYS:       cur_ways       = i_cfg_data[3:0];
                    CFG_BLOCK_BITS: cur_block_bits = i_cfg_data;
                    default: ;
                endcase
            end
            in_busy  = s_axis_tvalid && !s_axis_tready;
            cfg_busy = i_cfg_valid && !o_cfg_ready;
            if (!in_busy && !cfg_busy) begin
                if (request_q.size() == 0 || (!calm && $urandom_range(0, 99) < 6)) begin
                    s_axis_tvalid <= 1'b0;
                    i_cfg_valid   <= 1'b0;
                end else if (request_q[0].is_cfg) begin
                    s_axis_tvalid <= 1'b0;
                    // Registers change only once every result has come back.
                    if (accesses_sent == outcomes_seen) begin
                        nxt = request_q.pop_front();
                        i_cfg_valid <= 1'b1;
                        i_cfg_index <= nxt.cfg_index;
                        i_cfg_data  <= nxt.cfg_value;
                    end else begin
                        i_cfg_valid <= 1'b0;
                    end
                end else begin
                    nxt = request_q.pop_front();
                    i_cfg_valid   <= 1'b0;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nxt.addr;
                    s_axis_tuser  <= nxt.op;
                end
            end
        end
    end

    // Monitor and checker.
    always @(posedge i_clk) begin
        outcome_t got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = outcome_t'(m_axis_tdata[99:0]);
                outcomes_seen <= outcomes_seen + 1;
                if (outcome_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("%0t: result with no access outstanding", $realtime);
                end else begin
                    want = outcome_q.pop_front();
                    if (got.hit != want.hit)
                        note_mismatch("hit", want.hit, got.hit);
                    if (got.miss != want.miss)
                        note_mismatch("miss", want.miss, got.miss);
                    if (got.eviction != want.eviction)
                        note_mismatch("eviction", want.eviction, got.eviction);
                    if (got.second_hit != want.second_hit)
                        note_mismatch("second_hit", want.second_hit, got.second_hit);
                    if (got.hit_total != want.hit_total)
                        note_mismatch("hit_total", want.hit_total, got.hit_total);
                    if (got.miss_total != want.miss_total)
                        note_mismatch("miss_total", want.miss_total, got.miss_total);
                    if (got.eviction_total != want.eviction_total)
                        note_mismatch("eviction_total", want.eviction_total,
                                      got.eviction_total);
                end
            end
            m_axis_tready <= calm || ($urandom_range(0, 99) >= 6);
        end
    end

    initial begin
        int unsigned sb_list   [8] = '{0, 6, 7, 2, 3, 5, 1, 4};
        int unsigned ways_list [8] = '{1, 8, 15, 0, 4, 8, 2, 3};
        int unsigned bb_list   [8] = '{0, 26, 31, 5, 6, 2, 27, 12};
        int unsigned p, n, k, esb, nw, set_v, tag_v;
        logic [1:0]  op;
        logic [31:0] addr;
        logic [63:0] a64, off;

        gen_sb   = 4;
        gen_ways = 1;
        gen_bb   = 4;

        // Reset geometry: 16 sets, one way, 16-byte blocks.
        queue_access(OP_IFETCH, 32'h0000_0000);
        queue_access(OP_LOAD,   32'h0000_0000);
        queue_access(OP_LOAD,   32'h0000_000F);
        queue_access(OP_STORE,  32'h0000_0004);
        queue_access(OP_MODIFY, 32'h0000_0000);
        queue_access(OP_LOAD,   32'h0000_0100);
        queue_access(OP_MODIFY, 32'h0000_0000);
        queue_access(OP_STORE,  32'hFFFF_FFFF);
        queue_access(OP_LOAD,   32'hFFFF_FFF0);
        queue_access(OP_IFETCH, 32'hFFFF_FFFF);
        queue_access(OP_LOAD,   32'hAAAA_AAAA);
        queue_access(OP_STORE,  32'h5555_5555);
        queue_access(OP_MODIFY, 32'hAAAA_AAAA);
        queue_access(OP_IFETCH, 32'h5555_5555);
        // Two ways: fill set 1, refresh the first line, then force LRU victims.
        queue_config(CFG_WAYS, 2);
        queue_access(OP_LOAD,   32'h0000_0110);
        queue_access(OP_STORE,  32'h0000_0210);
        queue_access(OP_LOAD,   32'h0000_0118);
        queue_access(OP_MODIFY, 32'h0000_0310);
        queue_access(OP_LOAD,   32'h0000_0210);
        queue_access(OP_LOAD,   32'h0000_0314);

        for (p = 0; p < 8; p++) begin
            queue_config(CFG_SET_BITS, sb_list[p]);
            queue_config(CFG_WAYS, ways_list[p]);
            queue_config(CFG_BLOCK_BITS, bb_list[p]);
            esb = (gen_sb > MAX_SET_BITS) ? MAX_SET_BITS : gen_sb;
            nw  = (gen_ways == 0) ? 1 : ((gen_ways > MAX_WAYS) ? MAX_WAYS : gen_ways);
            for (n = 0; n < 210; n++) begin
                op = 2'($urandom_range(0, 3));
                if ($urandom_range(0, 99) < 15) begin
                    addr = $urandom;
                end else begin
                    // A few sets and slightly more tags than ways keep the
                    // sets full and the LRU choice busy.
                    set_v = $urandom_range(0, ((1 << esb) > 4) ? 3 : (1 << esb) - 1);
                    tag_v = $urandom_range(0, nw + 1);
                    off   = {$urandom, $urandom};
                    a64   = (64'(tag_v) << (gen_bb + esb)) | (64'(set_v) << gen_bb)
                          | (off & ((64'd1 << gen_bb) - 64'd1));
                    addr  = a64[31:0];
                end
                queue_access(op, addr);
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (request_q.size() != 0 || s_axis_tvalid || i_cfg_valid)
            @(negedge i_clk);
        for (k = 0; k < 2000 && outcome_q.size() != 0; k++)
            @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (outcome_q.size() != 0) begin
            fail_cnt += outcome_q.size();
            $display("%0d results never arrived", outcome_q.size());
        end

        if (fail_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Far beyond the slowest legal run of this stimulus.
    initial begin
        #3600000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
